>>> rtl/core/tab_expander_core_macros.svh
// Assertion macros used by the tab expander datapath.
`ifndef TAB_EXPANDER_CORE_MACROS_SVH
`define TAB_EXPANDER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tab expander check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tab expander check failed");

`else

`define CHK_IMP(lbl, clk, rst_n, ante, cons)
`define CHK_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/tabx_pkg.sv
// Shared types, constants and codes for the tab expander.
package tabx_pkg;

    localparam int CHAR_W        = 21;
    localparam int REP_W         = 16;
    localparam int STOP_W        = 16;
    localparam int TABW_W        = 7;
    localparam int CNT_W         = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int NUM_STOP_REGS = 4;

    localparam int DEF_COL_BITS  = 16;
    localparam int DEF_MAX_STOPS = 4;

    localparam logic [CHAR_W-1:0] CH_TAB   = 21'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 21'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE = 21'd32;

    localparam logic [TABW_W-1:0] DEF_TAB_WIDTH = 7'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAB_WIDTH  = 3'd0,
        REG_USE_STOPS  = 3'd1,
        REG_STOP_COUNT = 3'd2,
        REG_STOP_ZERO  = 3'd3,
        REG_STOP_ONE   = 3'd4,
        REG_STOP_TWO   = 3'd5,
        REG_STOP_THREE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [TABW_W-1:0]                     tab_width;
        logic                                  use_stops;
        logic [CNT_W-1:0]                      stop_count;
        logic [NUM_STOP_REGS-1:0][STOP_W-1:0]  stops;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic mod_step;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tab;
        logic use_stops;
        logic mod_last;
        logic scan_stop;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/core/tabx_cfg.sv
// Configuration register file of the tab expander.
module tabx_cfg
    import tabx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tab_width  <= DEF_TAB_WIDTH;
            r_cfg.use_stops  <= 1'b0;
            r_cfg.stop_count <= '0;
            r_cfg.stops      <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_TAB_WIDTH:  r_cfg.tab_width  <= i_cfg_data[TABW_W-1:0];
                REG_USE_STOPS:  r_cfg.use_stops  <= i_cfg_data[0];
                REG_STOP_COUNT: r_cfg.stop_count <= i_cfg_data[CNT_W-1:0];
                REG_STOP_ZERO:  r_cfg.stops[0]   <= i_cfg_data[STOP_W-1:0];
                REG_STOP_ONE:   r_cfg.stops[1]   <= i_cfg_data[STOP_W-1:0];
                REG_STOP_TWO:   r_cfg.stops[2]   <= i_cfg_data[STOP_W-1:0];
                REG_STOP_THREE: r_cfg.stops[3]   <= i_cfg_data[STOP_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

endmodule

>>> rtl/core/tabx_ctrl.sv
// Sequencing state machine of the tab expander.
module tabx_ctrl
    import tabx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.is_tab) begin
                    n_state = S_DONE;
                end else if (i_sts.use_stops) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.mod_last) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_stop) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.start = i_in_valid;
            end
            S_DECODE: begin
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/core/tabx_dp.sv
// Datapath of the tab expander: column, remainder unit, stop scan, result register.
`include "tab_expander_core_macros.svh"

module tabx_dp
    import tabx_pkg::*;
#(
    parameter int COL_BITS  = DEF_COL_BITS,
    parameter int MAX_STOPS = DEF_MAX_STOPS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [CHAR_W-1:0] i_ch,
    input  logic              i_first_of_text,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CHAR_W-1:0] o_out_char,
    output logic [REP_W-1:0]  o_repeat_res
);

    localparam int CMP_W     = (COL_BITS > STOP_W) ? COL_BITS : STOP_W;
    localparam int SUM_W     = CMP_W + 1;
    localparam int BIT_CNT_W = (COL_BITS > 1) ? $clog2(COL_BITS) : 1;
    localparam int IDX_W     = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

    localparam logic [SUM_W-1:0] COL_MAX =
        {{(SUM_W-COL_BITS){1'b0}}, {COL_BITS{1'b1}}};

    logic [CHAR_W-1:0]    r_ch;
    logic [COL_BITS-1:0]  r_column;
    logic [COL_BITS-1:0]  r_col_work;
    logic [COL_BITS-1:0]  r_col_shift;
    logic [TABW_W-1:0]    r_rem;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [IDX_W-1:0]     r_stop_idx;
    logic [REP_W-1:0]     r_dist;
    logic                 r_fixed;
    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic [REP_W-1:0]     r_out_rep;

    logic [TABW_W-1:0]    w_eff;
    logic [TABW_W:0]      rem_sh;
    logic [TABW_W-1:0]    n_rem;
    logic [CNT_W-1:0]     cnt_eff;
    logic [CNT_W-1:0]     idx_ext;
    logic [STOP_W-1:0]    stop_view [MAX_STOPS];
    logic [STOP_W-1:0]    stop_sel;
    logic [CMP_W-1:0]     stop_ext;
    logic [CMP_W-1:0]     col_ext;
    logic                 in_range;
    logic                 stop_hit;
    logic                 stop_last;
    logic [REP_W-1:0]     dist_final;
    logic [SUM_W-1:0]     col_sum;
    logic [COL_BITS-1:0]  n_column;
    logic                 out_free;
    logic                 is_tab;
    logic                 is_nl;
    logic [COL_BITS-1:0]  start_col;

    assign is_tab = (r_ch == CH_TAB);
    assign is_nl  = (r_ch == CH_NL);
    assign w_eff  = (i_cfg.tab_width == '0) ? TABW_W'(1) : i_cfg.tab_width;
    assign start_col = i_first_of_text ? '0 : r_column;

    // one bit of restoring remainder per cycle, MSB first
    assign rem_sh = {r_rem, r_col_shift[COL_BITS-1]};
    always_comb begin
        if (rem_sh >= {1'b0, w_eff}) begin
            n_rem = TABW_W'(rem_sh - {1'b0, w_eff});
        end else begin
            n_rem = rem_sh[TABW_W-1:0];
        end
    end

    // stop table scan, one entry per cycle
    always_comb begin
        for (int k = 0; k < MAX_STOPS; k++) begin
            stop_view[k] = i_cfg.stops[k];
        end
    end

    assign cnt_eff   = (i_cfg.stop_count > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS)
                                                              : i_cfg.stop_count;
    assign idx_ext   = CNT_W'(r_stop_idx);
    assign stop_sel  = stop_view[r_stop_idx];
    assign stop_ext  = CMP_W'(stop_sel);
    assign col_ext   = CMP_W'(r_col_work);
    assign in_range  = idx_ext < cnt_eff;
    assign stop_hit  = in_range && (stop_ext > col_ext);
    assign stop_last = (idx_ext + CNT_W'(1)) >= cnt_eff;

    assign dist_final = r_fixed ? REP_W'(w_eff - r_rem) : r_dist;
    assign col_sum    = SUM_W'(r_col_work) + SUM_W'(dist_final);

    always_comb begin
        if (is_nl) begin
            n_column = '0;
        end else if (col_sum > COL_MAX) begin
            n_column = COL_MAX[COL_BITS-1:0];
        end else begin
            n_column = col_sum[COL_BITS-1:0];
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.is_tab    = is_tab;
    assign o_sts.use_stops = i_cfg.use_stops;
    assign o_sts.mod_last  = (r_bit_cnt == '0);
    assign o_sts.scan_stop = !in_range || stop_hit || stop_last;
    assign o_sts.out_free  = out_free;

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ch        <= i_ch;
            r_col_work  <= start_col;
            r_col_shift <= start_col;
            r_rem       <= '0;
            r_bit_cnt   <= BIT_CNT_W'(COL_BITS - 1);
            r_stop_idx  <= '0;
            r_dist      <= REP_W'(1);
            r_fixed     <= (i_ch == CH_TAB) && !i_cfg.use_stops;
        end
        if (i_cmd.mod_step) begin
            r_rem       <= n_rem;
            r_col_shift <= {r_col_shift[COL_BITS-2:0], 1'b0};
            r_bit_cnt   <= r_bit_cnt - BIT_CNT_W'(1);
        end
        if (i_cmd.scan_step) begin
            if (stop_hit) begin
                r_dist <= REP_W'(stop_ext - col_ext);
            end
            if (!o_sts.scan_stop) begin
                r_stop_idx <= r_stop_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
        end else if (i_cmd.commit) begin
            r_column <= n_column;
        end
    end

    // result register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_char <= is_tab ? CH_SPACE : r_ch;
            r_out_rep  <= dist_final;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_repeat_res = r_out_rep;

    `CHK_IMP(a_rem_below_width, i_clk, i_rst_n, i_cmd.mod_step, r_rem < w_eff)
    `CHK_IMP(a_no_overwrite, i_clk, i_rst_n, i_cmd.commit, !r_out_valid || !i_out_stall)
    `CHK_NEXT(a_commit_shows, i_clk, i_rst_n, i_cmd.commit, r_out_valid)
    `CHK_IMP(a_rep_nonzero, i_clk, i_rst_n, r_out_valid, r_out_rep != '0)

endmodule

>>> rtl/core/tab_expander_core.sv
// Tab expander: takes one character per transfer and returns it, or a run of
// spaces for a tab, as a character plus repeat count, tracking the output
// column. An item is taken only while the sequencer is idle, so one item is
// in flight at a time: a plain character (newline included) passes from
// decode straight to the result; a tab in fixed mode runs the remainder unit,
// which retires one column bit per cycle; a tab in stop mode scans the stop
// table, one stop compared per cycle. The result sits in an output register,
// so a stalled result does not block the next transfer in, only the commit of
// the item after it.
// Configuration writes are always accepted and must happen while idle.
module tab_expander_core
    import tabx_pkg::*;
#(
    parameter int COL_BITS  = DEF_COL_BITS,
    parameter int MAX_STOPS = DEF_MAX_STOPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CHAR_W-1:0]     i_ch,
    input  logic                  i_first_of_text,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CHAR_W-1:0]     o_out_char,
    output logic [REP_W-1:0]      o_repeat_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    tabx_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tabx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tabx_dp #(
        .COL_BITS  (COL_BITS),
        .MAX_STOPS (MAX_STOPS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_ch            (i_ch),
        .i_first_of_text (i_first_of_text),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_repeat_res    (o_repeat_res)
    );

endmodule
